// ===== rtl/core/rpg_pkg.sv =====
package rpg_pkg;

    // Command codes carried in the slave-side tuser
    typedef enum logic [2:0] {
        OP_UPLOAD  = 3'd0,
        OP_ERASE   = 3'd1,
        OP_PLAY    = 3'd2,
        OP_STOP    = 3'd3,
        OP_INH_ON  = 3'd4,
        OP_INH_OFF = 3'd5,
        OP_DESTROY = 3'd6,
        OP_TICK    = 3'd7
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_NODEV   = 3'd2,
        ST_BUSY    = 3'd3,
        ST_PERM    = 3'd4,
        ST_IO      = 3'd5,
        ST_NOENT   = 3'd6
    } t_status;

    // Configuration register indexes
    localparam logic CFG_MAX_ON  = 1'b0;
    localparam logic CFG_MIN_OFF = 1'b1;

    localparam int TW = 15;                     // tick counter width
    localparam logic [TW-1:0] MAX_ON_RST = 15'd1000;
    localparam logic [TW-1:0] MIN_OFF_RST = 15'd0;

    // Classified command passed from front to back
    typedef struct packed {
        t_op           op;
        logic          id_ok;
        logic          upl_bad;
        logic [TW-1:0] len;
        logic          fail;
    } t_cmd;

    // Result word fields
    typedef struct packed {
        logic    pulse_active;
        logic    fault_latched;
        logic    power_level;
        logic    output_level;
        t_status status;
    } t_res;

endpackage

// ===== rtl/core/rpg_front.sv =====
module rpg_front
    import rpg_pkg::*;
(
    input  logic [2:0]    i_op,
    input  logic [121:0]  i_data,
    input  logic [TW-1:0] i_max_on,
    output t_cmd          o_cmd
);

    logic [7:0]  slot_id;
    logic        is_rumble;
    logic [15:0] direction;
    logic [15:0] trig_button;
    logic [15:0] trig_interval;
    logic [15:0] replay_delay;
    logic [15:0] replay_length;
    logic [15:0] strong_level;
    logic [15:0] weak_level;
    logic        drive_fail;
    logic        shape_bad;
    logic        len_bad;
    logic        level_bad;

    // Unpack the word
    assign slot_id       = i_data[7:0];
    assign is_rumble     = i_data[8];
    assign direction     = i_data[24:9];
    assign trig_button   = i_data[40:25];
    assign trig_interval = i_data[56:41];
    assign replay_delay  = i_data[72:57];
    assign replay_length = i_data[88:73];
    assign strong_level  = i_data[104:89];
    assign weak_level    = i_data[120:105];
    assign drive_fail    = i_data[121];

    // Check the effect description for upload
    assign shape_bad = !is_rumble || (direction != 16'd0) || (trig_button != 16'd0)
                       || (trig_interval != 16'd0) || (replay_delay != 16'd0);
    assign len_bad   = (replay_length == 16'd0) || (replay_length > {1'b0, i_max_on});
    assign level_bad = (strong_level == 16'd0) && (weak_level == 16'd0);

    // Build the classified command
    always_comb begin
        o_cmd.op      = t_op'(i_op);
        o_cmd.id_ok   = (slot_id == 8'd0);
        o_cmd.upl_bad = shape_bad || len_bad || level_bad;
        o_cmd.len     = replay_length[TW-1:0];
        o_cmd.fail    = drive_fail;
    end

endmodule

// ===== rtl/core/rpg_cmd_fifo.sv =====
module rpg_cmd_fifo
    import rpg_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/rpg_back.sv =====
module rpg_back
    import rpg_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [TW-1:0] i_min_off,
    input  logic          i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_cmd_pop,
    output logic          o_res_valid,
    output t_res          o_res,
    input  logic          i_res_ready
);

    logic          r_drive;
    logic          r_power;
    logic          r_fault;
    logic          r_inhibit;
    logic          r_gone;
    logic          r_loaded;
    logic [TW-1:0] r_pulse_len;
    logic [TW-1:0] r_ticks;
    logic [TW-1:0] r_quiet;
    logic          r_ever;
    logic          r_out_valid;
    t_res          r_out;

    logic          n_drive;
    logic          n_power;
    logic          n_fault;
    logic          n_inhibit;
    logic          n_gone;
    logic          n_loaded;
    logic [TW-1:0] n_pulse_len;
    logic [TW-1:0] n_ticks;
    logic [TW-1:0] n_quiet;
    logic          n_ever;
    t_status       n_status;
    logic          lower;
    t_status       lower_st;
    logic          exec;

    // Take a word when the result register is free or being drained
    assign exec      = i_cmd_valid && (!r_out_valid || i_res_ready);
    assign o_cmd_pop = exec;
    assign lower_st  = (r_drive && i_cmd.fail) ? ST_IO : ST_OK;

    // Carry out one command
    always_comb begin
        n_drive     = r_drive;
        n_power     = r_power;
        n_fault     = r_fault;
        n_inhibit   = r_inhibit;
        n_gone      = r_gone;
        n_loaded    = r_loaded;
        n_pulse_len = r_pulse_len;
        n_ticks     = r_ticks;
        n_quiet     = r_quiet;
        n_ever      = r_ever;
        n_status    = ST_OK;
        lower       = 1'b0;
        unique case (i_cmd.op)
            OP_UPLOAD: begin
                if (i_cmd.upl_bad) begin
                    n_status = ST_INVALID;
                end else if (r_gone) begin
                    n_status = ST_NODEV;
                end else if (r_drive) begin
                    n_status = ST_BUSY;
                end else begin
                    n_pulse_len = i_cmd.len;
                    n_loaded    = 1'b1;
                end
            end
            OP_ERASE: begin
                if (!i_cmd.id_ok) begin
                    n_status = ST_INVALID;
                end else begin
                    lower    = 1'b1;
                    n_loaded = 1'b0;
                    n_status = lower_st;
                end
            end
            OP_PLAY: begin
                if (!i_cmd.id_ok) begin
                    n_status = ST_INVALID;
                end else if (r_gone) begin
                    n_status = ST_NODEV;
                end else if (r_inhibit) begin
                    n_status = ST_PERM;
                end else if (r_fault) begin
                    n_status = ST_IO;
                end else if (!r_loaded) begin
                    n_status = ST_NOENT;
                end else if (r_drive || (r_ever && (r_quiet != '0))) begin
                    n_status = ST_BUSY;
                end else begin
                    n_drive = 1'b1;
                    if (i_cmd.fail) begin
                        // raise failed: the follow-up lowering fails too
                        n_fault  = 1'b1;
                        n_ticks  = '0;
                        n_power  = 1'b0;
                        n_status = ST_IO;
                    end else begin
                        n_power = 1'b1;
                        n_ticks = r_pulse_len;
                    end
                end
            end
            OP_STOP: begin
                if (!i_cmd.id_ok) begin
                    n_status = ST_INVALID;
                end else begin
                    lower    = 1'b1;
                    n_status = lower_st;
                end
            end
            OP_INH_ON: begin
                if (r_gone) begin
                    n_status = ST_NODEV;
                end else begin
                    n_inhibit = 1'b1;
                    lower     = 1'b1;
                    n_status  = lower_st;
                end
            end
            OP_INH_OFF: begin
                if (r_gone) begin
                    n_status = ST_NODEV;
                end else begin
                    n_inhibit = 1'b0;
                end
            end
            OP_DESTROY: begin
                n_gone    = 1'b1;
                n_inhibit = 1'b1;
                lower     = 1'b1;
                n_status  = lower_st;
            end
            OP_TICK: begin
                if (r_quiet != '0) begin
                    n_quiet = r_quiet - 1'b1;
                end
                if (r_ticks != '0) begin
                    n_ticks = r_ticks - 1'b1;
                    // expiry on the last tick
                    if (r_ticks == TW'(1)) begin
                        lower = 1'b1;
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase

        // Lower the pin and drop power
        if (lower) begin
            n_ticks = '0;
            n_power = 1'b0;
            if (r_drive) begin
                if (i_cmd.fail) begin
                    n_fault = 1'b1;
                end else begin
                    n_drive = 1'b0;
                    n_ever  = 1'b1;
                    n_quiet = i_min_off;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive     <= 1'b0;
            r_power     <= 1'b0;
            r_fault     <= 1'b0;
            r_inhibit   <= 1'b0;
            r_gone      <= 1'b0;
            r_loaded    <= 1'b0;
            r_pulse_len <= '0;
            r_ticks     <= '0;
            r_quiet     <= '0;
            r_ever      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec) begin
                r_drive     <= n_drive;
                r_power     <= n_power;
                r_fault     <= n_fault;
                r_inhibit   <= n_inhibit;
                r_gone      <= n_gone;
                r_loaded    <= n_loaded;
                r_pulse_len <= n_pulse_len;
                r_ticks     <= n_ticks;
                r_quiet     <= n_quiet;
                r_ever      <= n_ever;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Register the result word
    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out.status        <= n_status;
            r_out.output_level  <= n_drive;
            r_out.power_level   <= n_power;
            r_out.fault_latched <= n_fault;
            r_out.pulse_active  <= (n_ticks != '0);
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== rtl/core/rumble_pulse_guard_unit.sv =====
// Path: an accepted word is written into the command queue, then executed and registered
// in the executor's result register, which presents it on the master side.
// Throughput: one word per cycle while m_axis_tready is high, set by the result register.
// Reset: synchronous active-low i_rst_n empties the queue, clears all motor state and
// loads the maximum on-time limit with 1000 ticks and the minimum off-time with 0.
module rumble_pulse_guard_unit
    import rpg_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // tdata: slot_id[7:0], is_rumble[8], direction[24:9], trigger_button[40:25],
    //        trigger_interval[56:41], replay_delay[72:57], replay_length[88:73],
    //        strong_level[104:89], weak_level[120:105], drive_fail[121], zero fill
    input  logic [127:0]  s_axis_tdata,
    // tuser: op[2:0]
    input  logic [2:0]    s_axis_tuser,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: status[2:0], output_level[3], power_level[4], fault_latched[5],
    //        pulse_active[6], zero fill
    output logic [7:0]    m_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic          i_cfg_we,
    input  logic          i_cfg_addr,
    input  logic [TW-1:0] i_cfg_wdata
);

    logic [TW-1:0] r_max_on;
    logic [TW-1:0] r_min_off;
    t_cmd          front_cmd;
    t_cmd          q_cmd;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    t_res          res;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_on  <= MAX_ON_RST;
            r_min_off <= MIN_OFF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAX_ON:  r_max_on  <= i_cfg_wdata;
                CFG_MIN_OFF: r_min_off <= i_cfg_wdata;
                default:     r_max_on  <= r_max_on;
            endcase
        end
    end

    rpg_front u_front (
        .i_op     (s_axis_tuser),
        .i_data   (s_axis_tdata[121:0]),
        .i_max_on (r_max_on),
        .o_cmd    (front_cmd)
    );

    rpg_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    rpg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_min_off   (r_min_off),
        .i_cmd_valid (!q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign s_axis_tready = !q_full;
    assign m_axis_tdata  = {1'b0, res};

endmodule
